// ----- design/shp3_pkg.sv -----
// ----------------------------------------------------------------------------
// shp3_pkg
// Shared types and constants for the 3x3 cross-kernel sharpen unit.
// ----------------------------------------------------------------------------
package shp3_pkg;

   localparam int MAX_LINE_SAMPLES_DEF = 4096;
   localparam int SAMPLE_W             = 8;
   localparam int CSR_INDEX_W          = 2;
   localparam int CSR_DATA_W           = 13;
   localparam int CHAN_W               = 3;
   localparam int WIDTH_W              = 11;
   localparam int HEIGHT_W             = 13;
   localparam int CHAN_MAX             = 4;

   localparam logic [CHAN_W-1:0]   CHANNELS_RST = 3'd3;
   localparam logic [WIDTH_W-1:0]  WIDTH_RST    = 11'd640;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RST   = 13'd480;

   // register indexes on the CSR port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CHANNEL_COUNT = 2'd0,
      CSR_WIDTH_PIXELS  = 2'd1,
      CSR_HEIGHT_ROWS   = 2'd2
   } csr_index_type;

   // per-sample position flags from the sequencer
   typedef struct packed {
      logic produce;    // row above exists: a result is due
      logic border;     // result is forced to zero
      logic frame_end;  // last result of the frame
   } pos_info_type;

endpackage

// ----- design/sharpen_3x3_filter_unit.sv -----
// ----------------------------------------------------------------------------
// sharpen_3x3_filter_unit
// 3x3 cross-kernel sharpen on a raster stream of interleaved 8-bit samples.
// ----------------------------------------------------------------------------
// One sample per clock in, one result per clock out while rsp_ready does
// not stall the output. Each accepted transaction carries a sample of row
// r; the unit returns the result for row r-1 at the same position
// (5*centre minus left, right, above, below, clamped to 0..255, zero on
// the image border). Row 0 samples return nothing. After the image rows,
// send one more row of samples (values ignored) to get the final zero row;
// frame_end marks the last result. rsp_valid is registered: a sample passes
// stage 1, then the output register, and either can hold it on a stall.
// Throughput is one transaction per cycle when not stalled, set by the line
// store: it reads the current and the right-hand position at acceptance and
// writes the shifted pair back as the transaction leaves stage 1. Any CSR
// write to a known register restarts the frame; write only while idle. The
// line store is not cleared; it is filled by the frame before it is read.
// ----------------------------------------------------------------------------
module sharpen_3x3_filter_unit
   import shp3_pkg::*;
#(
   parameter int MAX_LINE_SAMPLES = MAX_LINE_SAMPLES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // input samples
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_W-1:0]    req_sample,
   // results
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SAMPLE_W-1:0]    rsp_sharpened,
   output logic                   rsp_frame_end,
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = $clog2(MAX_LINE_SAMPLES);

   // sequencer outputs
   logic [CHAN_W-1:0]     channels;
   logic [AW-1:0]         addr_centre;
   logic [AW-1:0]         addr_right;
   pos_info_type          pos_info;

   // line store
   logic [2*SAMPLE_W-1:0] rd_centre_word;
   logic [2*SAMPLE_W-1:0] rd_right_word;
   logic                  mem_we;

   // stage 1: memory data valid, kernel evaluates
   logic                  s1_valid_ff,  s1_valid_in;
   pos_info_type          s1_info_ff;
   logic [SAMPLE_W-1:0]   s1_below_ff;
   logic [AW-1:0]         s1_addr_ff;
   logic                  s1_go;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]   rsp_sharpened_ff;
   logic                  rsp_frame_end_ff;

   logic                  req_accept;
   logic [SAMPLE_W-1:0]   above;
   logic [SAMPLE_W-1:0]   centre;
   logic [SAMPLE_W-1:0]   right;
   logic [SAMPLE_W-1:0]   kernel_out;

   // handshakes: stage 1 drains when it has no result or the output slot
   // frees up this cycle
   assign s1_go      = !s1_info_ff.produce || !rsp_valid_ff || rsp_ready;
   assign req_ready  = !s1_valid_ff || s1_go;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign mem_we     = s1_valid_ff && s1_go;

   shp3_seq #(
      .MAX_LINE_SAMPLES (MAX_LINE_SAMPLES),
      .AW               (AW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .advance     (req_accept),
      .channels    (channels),
      .addr_centre (addr_centre),
      .addr_right  (addr_right),
      .info        (pos_info)
   );

   // word layout: upper byte = row above, lower byte = centre row
   shp3_line_mem #(
      .DEPTH (MAX_LINE_SAMPLES),
      .AW    (AW)
   ) u_line_mem (
      .clock     (clock),
      .rd_en     (req_accept),
      .rd_addr_a (addr_centre),
      .rd_addr_b (addr_right),
      .rd_data_a (rd_centre_word),
      .rd_data_b (rd_right_word),
      .wr_en     (mem_we),
      .wr_addr   (s1_addr_ff),
      .wr_data   ({centre, s1_below_ff})
   );

   assign above  = rd_centre_word[2*SAMPLE_W-1:SAMPLE_W];
   assign centre = rd_centre_word[SAMPLE_W-1:0];
   assign right  = rd_right_word[SAMPLE_W-1:0];

   shp3_kernel u_kernel (
      .clock     (clock),
      .shift_en  (mem_we),
      .channels  (channels),
      .above     (above),
      .centre    (centre),
      .right     (right),
      .below     (s1_below_ff),
      .border    (s1_info_ff.border),
      .sharpened (kernel_out)
   );

   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (mem_we && s1_info_ff.produce) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // stage 1 payload, loaded with the memory read
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_info_ff  <= pos_info;
         s1_below_ff <= req_sample;
         s1_addr_ff  <= addr_centre;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (mem_we && s1_info_ff.produce) begin
         rsp_sharpened_ff <= kernel_out;
         rsp_frame_end_ff <= s1_info_ff.frame_end;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sharpened = rsp_sharpened_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

`ifndef SYNTHESIS
   // the last row is border, so the frame-end result is always zero
   a_frame_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_sharpened == '0)
      else $error("frame end result is not zero");

   // write-back never collides with a read of the same entry
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      req_accept && mem_we |-> (addr_centre != s1_addr_ff)
                               && (addr_right != s1_addr_ff))
      else $error("line store read and write hit the same entry");

   // an accepted transaction always occupies stage 1 next cycle
   a_accept_loads_s1: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted transaction lost before stage 1");

   // a stalled stage 1 keeps its transaction
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_go |=> s1_valid_ff && $stable(s1_below_ff)
                                && $stable(s1_addr_ff))
      else $error("stalled stage 1 lost its contents");
`endif

endmodule

// ----- design/shp3_line_mem.sv -----
// ----------------------------------------------------------------------------
// shp3_line_mem
// Line store: one word per sample position holding {row above, centre row}.
// One write port, two registered read ports.
// ----------------------------------------------------------------------------
module shp3_line_mem
   import shp3_pkg::*;
#(
   parameter int DEPTH = MAX_LINE_SAMPLES_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr_a,
   input  logic [AW-1:0]         rd_addr_b,
   output logic [2*SAMPLE_W-1:0] rd_data_a,
   output logic [2*SAMPLE_W-1:0] rd_data_b,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [2*SAMPLE_W-1:0] wr_data
);

   logic [2*SAMPLE_W-1:0] store_ff [DEPTH];
   logic [2*SAMPLE_W-1:0] rd_a_ff;
   logic [2*SAMPLE_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= store_ff[rd_addr_a];
         rd_b_ff <= store_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- design/shp3_seq.sv -----
// ----------------------------------------------------------------------------
// shp3_seq
// Configuration registers and raster position counters. Derives the
// effective geometry, the line store addresses and the per-sample flags.
// ----------------------------------------------------------------------------
module shp3_seq
   import shp3_pkg::*;
#(
   parameter int MAX_LINE_SAMPLES = MAX_LINE_SAMPLES_DEF,
   parameter int AW               = $clog2(MAX_LINE_SAMPLES)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   advance,
   output logic [CHAN_W-1:0]      channels,
   output logic [AW-1:0]          addr_centre,
   output logic [AW-1:0]          addr_right,
   output pos_info_type           info
);

   localparam int LW   = $clog2(MAX_LINE_SAMPLES + 1);
   localparam int CAPW = (LW > WIDTH_W) ? LW : WIDTH_W;
   localparam logic [CAPW-1:0] CAP1 = CAPW'(MAX_LINE_SAMPLES / 1);
   localparam logic [CAPW-1:0] CAP2 = CAPW'(MAX_LINE_SAMPLES / 2);
   localparam logic [CAPW-1:0] CAP3 = CAPW'(MAX_LINE_SAMPLES / 3);
   localparam logic [CAPW-1:0] CAP4 = CAPW'(MAX_LINE_SAMPLES / 4);

   logic [CHAN_W-1:0]   chan_ff,   chan_in;
   logic [WIDTH_W-1:0]  width_ff,  width_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic [AW-1:0]       samp_ff,   samp_in;
   logic [HEIGHT_W-1:0] row_ff,    row_in;

   logic [CHAN_W-1:0]   ch_eff;
   logic [CAPW-1:0]     cap;
   logic [WIDTH_W-1:0]  w_clamp;
   logic [CAPW-1:0]     w_eff;
   logic [LW-1:0]       len;
   logic [HEIGHT_W-1:0] h_eff;
   logic [LW-1:0]       samp_ext;
   logic [LW:0]         right_sum;
   logic                csr_hit;
   logic                row_last;

   // effective geometry
   always_comb begin
      if (chan_ff == '0) begin
         ch_eff = CHAN_W'(1);
      end else if (chan_ff > CHAN_W'(CHAN_MAX)) begin
         ch_eff = CHAN_W'(CHAN_MAX);
      end else begin
         ch_eff = chan_ff;
      end

      unique case (ch_eff)
         CHAN_W'(1): cap = CAP1;
         CHAN_W'(2): cap = CAP2;
         CHAN_W'(3): cap = CAP3;
         default:    cap = CAP4;
      endcase

      if (width_ff < WIDTH_W'(3)) begin
         w_clamp = WIDTH_W'(3);
      end else if (width_ff > WIDTH_W'(1024)) begin
         w_clamp = WIDTH_W'(1024);
      end else begin
         w_clamp = width_ff;
      end

      w_eff = (CAPW'(w_clamp) > cap) ? cap : CAPW'(w_clamp);
      len   = LW'(ch_eff * w_eff);

      if (height_ff < HEIGHT_W'(3)) begin
         h_eff = HEIGHT_W'(3);
      end else if (height_ff > HEIGHT_W'(4096)) begin
         h_eff = HEIGHT_W'(4096);
      end else begin
         h_eff = height_ff;
      end
   end

   // position decode
   always_comb begin
      samp_ext  = LW'(samp_ff);
      right_sum = (LW+1)'(samp_ext) + (LW+1)'(ch_eff);
      row_last  = (samp_ext == len - LW'(1));

      addr_centre = samp_ff;
      addr_right  = (right_sum < (LW+1)'(len)) ? AW'(right_sum) : samp_ff;

      info.produce   = (row_ff != '0);
      info.border    = (row_ff == HEIGHT_W'(1)) || (row_ff == h_eff)
                       || (samp_ext < LW'(ch_eff))
                       || (samp_ext >= len - LW'(ch_eff));
      info.frame_end = (row_ff == h_eff) && row_last;
   end

   assign channels = ch_eff;

   // CSR writes and counter advance
   always_comb begin
      chan_in   = chan_ff;
      width_in  = width_ff;
      height_in = height_ff;
      samp_in   = samp_ff;
      row_in    = row_ff;
      csr_hit   = 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_CHANNEL_COUNT: begin
               chan_in = csr_wdata[CHAN_W-1:0];
               csr_hit = 1'b1;
            end
            CSR_WIDTH_PIXELS: begin
               width_in = csr_wdata[WIDTH_W-1:0];
               csr_hit  = 1'b1;
            end
            CSR_HEIGHT_ROWS: begin
               height_in = csr_wdata[HEIGHT_W-1:0];
               csr_hit   = 1'b1;
            end
            default: csr_hit = 1'b0;
         endcase
      end

      if (csr_hit) begin
         samp_in = '0;
         row_in  = '0;
      end else if (advance) begin
         if (row_last) begin
            samp_in = '0;
            row_in  = (row_ff >= h_eff) ? '0 : row_ff + HEIGHT_W'(1);
         end else begin
            samp_in = samp_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff   <= CHANNELS_RST;
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         samp_ff   <= '0;
         row_ff    <= '0;
      end else begin
         chan_ff   <= chan_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         samp_ff   <= samp_in;
         row_ff    <= row_in;
      end
   end

endmodule

// ----- design/shp3_kernel.sv -----
// ----------------------------------------------------------------------------
// shp3_kernel
// Cross-kernel arithmetic: 5*centre - left - right - above - below with
// saturation. Keeps the last few centre samples to supply the left tap.
// ----------------------------------------------------------------------------
module shp3_kernel
   import shp3_pkg::*;
(
   input  logic                clock,
   input  logic                shift_en,
   input  logic [CHAN_W-1:0]   channels,
   input  logic [SAMPLE_W-1:0] above,
   input  logic [SAMPLE_W-1:0] centre,
   input  logic [SAMPLE_W-1:0] right,
   input  logic [SAMPLE_W-1:0] below,
   input  logic                border,
   output logic [SAMPLE_W-1:0] sharpened
);

   localparam int ACC_W = SAMPLE_W + 4;
   localparam int SEL_W = $clog2(CHAN_MAX);

   logic [SAMPLE_W-1:0]     hist_ff [CHAN_MAX];
   logic [SEL_W-1:0]        left_sel;
   logic [SAMPLE_W-1:0]     left;
   logic signed [ACC_W-1:0] acc;

   // centre history, newest first; tap channels-1 is the same channel one
   // pixel to the left
   always_ff @(posedge clock) begin
      if (shift_en) begin
         hist_ff[0] <= centre;
         for (int i = 1; i < CHAN_MAX; i++) begin
            hist_ff[i] <= hist_ff[i-1];
         end
      end
   end

   always_comb begin
      left_sel = SEL_W'(channels - CHAN_W'(1));
      left     = hist_ff[left_sel];

      acc = $signed({2'b00, centre, 2'b00}) + $signed({4'b0000, centre})
            - $signed({4'b0000, left}) - $signed({4'b0000, right})
            - $signed({4'b0000, above}) - $signed({4'b0000, below});

      if (border || acc[ACC_W-1]) begin
         sharpened = '0;
      end else if (acc > ACC_W'(255)) begin
         sharpened = '1;
      end else begin
         sharpened = acc[SAMPLE_W-1:0];
      end
   end

endmodule
